// File: src/lfbl_pkg.sv
// ---------------------------------------------------------------------------
// lfbl_pkg
// Shared widths, status codes and types of the linked free block list.
// ---------------------------------------------------------------------------
package lfbl_pkg;

	localparam int ADDR_W  = 10;
	localparam int COUNT_W = 11;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_CORRUPT  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

endpackage

// File: src/lfbl_ram.sv
// ---------------------------------------------------------------------------
// lfbl_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module lfbl_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/linked_free_block_list.sv
// ---------------------------------------------------------------------------
// linked_free_block_list
// Free block pool kept as a linked list in an on-chip link memory.
// ---------------------------------------------------------------------------
// Each input transaction is a push (free one block, s_tuser = 0) or a pop
// (allocate one block, s_tuser = 1) and yields exactly one result
// transaction. A push writes the block's next link into the link memory,
// makes the block the head and raises the free count; a push onto a full
// pool or with a block number of NUM_BLOCKS or more reports overflow and
// changes nothing. A pop hands out the head block and follows its stored
// link; an empty pool reports empty, and a head that links to itself while
// more than one block is counted reports a corrupted list, both with no
// change. A push, or a pop on an empty pool, loads its result directly;
// any other pop first reads the head block's link from the link memory in
// state S_POP. One transaction is in flight at a time. The result sits in an
// output register, so the next input transaction is taken in the same cycle
// that the pending result is taken. The link memory needs no clearing pass:
// only pushed blocks can ever become the head.
// ---------------------------------------------------------------------------
module linked_free_block_list
	import lfbl_pkg::*;
#(
	parameter int NUM_BLOCKS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] block_addr, [15:10] zero
	input  logic        s_tuser,   // [0] opcode
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [9:0] alloc_addr, [20:10] free_left, [23:21] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	// Only block numbers below 2**ADDR_W can ever be pushed.
	localparam int DEPTH   = (NUM_BLOCKS > (1 << ADDR_W)) ? (1 << ADDR_W) : NUM_BLOCKS;
	localparam int AW      = $clog2(DEPTH);
	localparam int CAP_INT = (NUM_BLOCKS > ((1 << COUNT_W) - 1)) ?
	                         ((1 << COUNT_W) - 1) : NUM_BLOCKS;
	localparam count_t CAP = COUNT_W'(CAP_INT);

	typedef enum logic {
		S_IDLE,
		S_POP
	} state_t;

	state_t  state_q;
	addr_t   head_q;
	count_t  count_q;

	logic    out_valid_q;
	status_t out_status_q;
	addr_t   out_alloc_q;
	count_t  out_free_q;

	logic    accept;
	op_t     op;
	addr_t   in_addr;
	logic    out_free;
	logic    push_ok;
	logic    ram_we;
	logic    ram_re;
	addr_t   ram_wdata;
	addr_t   link_rd;
	logic    corrupt;
	logic    result_load;

	assign op       = op_t'(s_tuser);
	assign in_addr  = s_tdata[ADDR_W-1:0];
	// Output register is free now or frees at this edge.
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	assign push_ok   = (count_q < CAP) && (32'(in_addr) < 32'(NUM_BLOCKS));
	assign ram_we    = accept && (op == OP_PUSH) && push_ok;
	// Link of a first block points at itself.
	assign ram_wdata = (count_q == '0) ? in_addr : head_q;
	assign ram_re    = accept && (op == OP_POP) && (count_q != '0);

	// A result is loaded by every accepted transaction except a pop that
	// has to wait for the head's link, and by that pop in state S_POP.
	assign result_load = (state_q == S_POP) ||
	                     (accept && !((op == OP_POP) && (count_q != '0)));

	lfbl_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_addr[AW-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_q[AW-1:0]),
		.rdata (link_rd)
	);

	assign corrupt = (link_rd == head_q) && (count_q > COUNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_alloc_q  <= '0;
			out_free_q   <= '0;
		end else begin
			// Hold a new result, else drop the current one once taken.
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op == OP_PUSH) begin
							out_alloc_q <= '0;
							if (push_ok) begin
								head_q       <= in_addr;
								count_q      <= count_q + COUNT_W'(1);
								out_status_q <= ST_OK;
								out_free_q   <= count_q + COUNT_W'(1);
							end else begin
								out_status_q <= ST_OVERFLOW;
								out_free_q   <= count_q;
							end
						end else if (count_q == '0) begin
							out_status_q <= ST_EMPTY;
							out_alloc_q  <= '0;
							out_free_q   <= count_q;
						end else begin
							// Wait for the head's link to come back.
							state_q <= S_POP;
						end
					end
				end
				S_POP: begin
					state_q <= S_IDLE;
					if (corrupt) begin
						out_status_q <= ST_CORRUPT;
						out_alloc_q  <= '0;
						out_free_q   <= count_q;
					end else begin
						head_q       <= link_rd;
						count_q      <= count_q - COUNT_W'(1);
						out_status_q <= ST_OK;
						out_alloc_q  <= head_q;
						out_free_q   <= count_q - COUNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {3'b000, out_free_q, out_alloc_q};

endmodule

// File: tb/tb_linked_free_block_list.sv
// ---------------------------------------------------------------------------
// tb_linked_free_block_list
// Self-checking testbench for the linked free block list.
// ---------------------------------------------------------------------------
// Push and pop transactions go into the slave side and each result is checked
// against a cycle-free model of the pool: a link memory, a head block and a
// free count, updated whenever an input transaction is accepted. Directed
// tests cover the empty pool, extreme block numbers, the last block leaving,
// a self-linked (corrupted) list, and a full pool. A random test then runs
// an allocator that mostly frees blocks it holds, with some stray pushes
// mixed in. Both sides idle at random, with quiet stretches in between.
// ---------------------------------------------------------------------------
module tb_linked_free_block_list;
	import lfbl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BLOCKS = 1024;
	// count is 11 bits wide, so the pool can never hold more than 2047
	localparam int POOL_CAP = (NUM_BLOCKS > 2047) ? 2047 : NUM_BLOCKS;
	localparam int RANDOM_OPS = 400;

	typedef struct packed {
		status_t status;
		addr_t   alloc_addr;
		count_t  free_left;
	} pool_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [9:0] block_addr, [15:10] zero
	logic        s_tuser;   // [0] opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [9:0] alloc_addr, [20:10] free_left, [23:21] zero
	logic [1:0]  m_tuser;   // [1:0] status

	// pool model, advanced once per accepted input transaction
	addr_t  link_mem [NUM_BLOCKS];
	addr_t  pool_head;
	count_t pool_count;
	// blocks the allocator currently owns (not in the pool as far as it knows)
	bit     held [NUM_BLOCKS];

	pool_result_t expected_results [$];
	int           mismatch_count;
	int           result_count;
	bit           src_steady;
	bit           sink_steady;

	linked_free_block_list #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Apply one push or pop to the model and return the result it must give.
	function automatic pool_result_t apply_pool_op(input op_t op, input addr_t addr);
		pool_result_t r;
		addr_t        next_blk;
		r.status     = ST_OK;
		r.alloc_addr = '0;
		if (op == OP_PUSH) begin
			if (pool_count >= POOL_CAP || addr >= NUM_BLOCKS) begin
				r.status = ST_OVERFLOW;
			end else begin
				// first block into an empty pool links to itself
				link_mem[addr] = (pool_count == 0) ? addr : pool_head;
				pool_head      = addr;
				pool_count     = pool_count + 1'b1;
			end
		end else if (pool_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			next_blk = link_mem[pool_head];
			if (next_blk == pool_head && pool_count > 1) begin
				r.status = ST_CORRUPT;
			end else begin
				r.alloc_addr = pool_head;
				pool_head    = next_blk;
				pool_count   = pool_count - 1'b1;
			end
		end
		r.free_left = pool_count;
		return r;
	endfunction

	function automatic int draw_gap(input bit steady);
		return steady ? 0 : $urandom_range(0, 15);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// Send one transaction, then book its expected result once it is taken.
	task automatic send_op(input op_t op, input addr_t addr);
		int           gap;
		pool_result_t r;
		gap = draw_gap(src_steady);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'b0, addr};
		do @(posedge clk); while (!s_tready);
		r = apply_pool_op(op, addr);
		expected_results.push_back(r);
		if (r.status == ST_OK) begin
			if (op == OP_PUSH)
				held[addr] = 1'b0;
			else
				held[r.alloc_addr] = 1'b1;
		end
	endtask

	// Pop until the pool is empty; break any self-link that would stall it by
	// pushing a neighbour and then the head again, so the head links onwards.
	task automatic drain_pool();
		addr_t stuck;
		while (pool_count != 0) begin
			if (link_mem[pool_head] == pool_head && pool_count > 1) begin
				stuck = pool_head;
				send_op(OP_PUSH, stuck ^ 10'h001);
				send_op(OP_PUSH, stuck);
			end
			send_op(OP_POP, '0);
		end
	endtask

	function automatic addr_t pick_held_block();
		int start;
		int idx;
		start = $urandom_range(0, NUM_BLOCKS - 1);
		for (int k = 0; k < NUM_BLOCKS; k++) begin
			idx = (start + k) % NUM_BLOCKS;
			if (held[idx])
				return addr_t'(idx);
		end
		return addr_t'(start);
	endfunction

	// Empty pool, extreme block numbers, last block leaving, LIFO order.
	task automatic test_basic_order();
		send_op(OP_POP, 10'h3FF);
		send_op(OP_PUSH, 10'h000);
		send_op(OP_POP, '0);
		send_op(OP_POP, '0);
		send_op(OP_PUSH, 10'h3FF);
		send_op(OP_PUSH, 10'h155);
		send_op(OP_PUSH, 10'h2AA);
		send_op(OP_PUSH, 10'h000);
		repeat (5) send_op(OP_POP, '0);
	endtask

	// The same block pushed twice links to itself: pops see a corrupted list.
	task automatic test_corrupt_list();
		send_op(OP_PUSH, 10'h0F0);
		send_op(OP_PUSH, 10'h0F0);
		send_op(OP_POP, '0);
		send_op(OP_POP, '0);
		drain_pool();
		send_op(OP_POP, '0);
	endtask

	// Fill every block, overflow at both ends of the range, then empty it.
	task automatic test_full_pool();
		src_steady = 1'b1;
		for (int i = 0; i < NUM_BLOCKS; i++)
			send_op(OP_PUSH, addr_t'((i * 37) % NUM_BLOCKS));
		src_steady = 1'b0;
		send_op(OP_PUSH, 10'h000);
		send_op(OP_PUSH, 10'h3FF);
		drain_pool();
		send_op(OP_POP, '0);
	endtask

	// Allocator traffic: mostly frees of owned blocks, some stray pushes.
	task automatic test_random_traffic();
		int pop_pct;
		for (int seg = 0; seg < 4; seg++) begin
			src_steady  = seg[0];
			sink_steady = seg[1];
			for (int i = 0; i < RANDOM_OPS / 4; i++) begin
				pop_pct = (pool_count > 900) ? 80 : 45;
				if ($urandom_range(0, 99) < pop_pct)
					send_op(OP_POP, addr_t'($urandom()));
				else if ($urandom_range(0, 99) < 6)
					send_op(OP_PUSH, addr_t'($urandom()));
				else
					send_op(OP_PUSH, pick_held_block());
			end
		end
		src_steady  = 1'b0;
		sink_steady = 1'b0;
		drain_pool();
	endtask

	// result side: stall at random, hold ready until a result is taken
	initial begin
		int gap;
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = draw_gap(sink_steady);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		pool_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			result_count++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none expected",
					result_count));
			end else begin
				e = expected_results.pop_front();
				if (m_tuser != e.status)
					report_mismatch($sformatf("result %0d status %0d, want %0d",
						result_count, m_tuser, e.status));
				if (m_tdata[9:0] != e.alloc_addr)
					report_mismatch($sformatf("result %0d alloc_addr %0h, want %0h",
						result_count, m_tdata[9:0], e.alloc_addr));
				if (m_tdata[20:10] != e.free_left)
					report_mismatch($sformatf("result %0d free_left %0d, want %0d",
						result_count, m_tdata[20:10], e.free_left));
			end
		end
	end

	initial begin
		#20_000_000;
		$display("linked_free_block_list verification failed");
		$finish;
	end

	initial begin
		mismatch_count = 0;
		result_count   = 0;
		src_steady     = 1'b0;
		sink_steady    = 1'b0;
		pool_head      = '0;
		pool_count     = '0;
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			link_mem[i] = '0;
			held[i]     = 1'b1;
		end
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_PUSH;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_order();
		test_corrupt_list();
		test_full_pool();
		test_random_traffic();

		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		// watch a little longer for stray results
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("linked_free_block_list verification clean");
		else
			$display("linked_free_block_list verification failed");
		$finish;
	end

endmodule
